/* design/lbs_pkg.sv */
// shared types, opcodes and saturation helper for the skinning core
// no dependencies
package lbs_pkg;

    localparam int NUM_INF  = 4;
    localparam int NUM_ELEM = 16;
    localparam int NUM_ROW  = 3;
    localparam int ID_W     = 6;
    localparam int WT_W     = 17;

    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_POINT  = 2'd1;
    localparam logic [1:0] OP_NORMAL = 2'd2;
    localparam logic [1:0] OP_SPARE  = 2'd3;

    localparam logic [WT_W-1:0] Q_ONE = 17'h10000;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [9:0]         matrix_slot;
        logic [23:0]        bone_ids;
        logic [16:0]        weight0;
        logic [16:0]        weight1;
        logic [16:0]        weight2;
        logic [16:0]        weight3;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [31:0] coord_z;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic               saturated;
    } t_out_item;

    // per-vertex control carried down the pipe
    typedef struct packed {
        logic               pass;
        logic               point;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } t_vtx_ctl;

    typedef struct packed {
        logic               clip;
        logic signed [31:0] val;
    } t_sat;

    localparam logic signed [65:0] S32_MAX = 66'sd2147483647;
    localparam logic signed [65:0] S32_MIN = -66'sd2147483648;

    function automatic t_sat sat32(input logic signed [65:0] v);
        t_sat s;
        s.clip = 1'b1;
        if (v > S32_MAX) begin
            s.val = 32'sh7fffffff;
        end else if (v < S32_MIN) begin
            s.val = 32'sh80000000;
        end else begin
            s.clip = 1'b0;
            s.val  = v[31:0];
        end
        return s;
    endfunction

endpackage

/* design/lbs_bank.sv */
// one copy of the bone matrix table, one row per bone
// element-wide write, whole-row registered read; uses nothing else
module lbs_bank #(
    parameter int MAX_BONES = 64,
    parameter int BONE_W    = 6
) (
    input  logic                  i_clk,
    input  logic                  i_wr_en,
    input  logic [BONE_W-1:0]     i_wr_bone,
    input  logic [3:0]            i_wr_elem,
    input  logic [31:0]           i_wr_data,
    input  logic                  i_rd_en,
    input  logic [BONE_W-1:0]     i_rd_bone,
    output logic [15:0][31:0]     o_rd_row
);

    logic [15:0][31:0] mem [MAX_BONES];
    logic [15:0][31:0] r_row;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_bone][i_wr_elem] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_row <= mem[i_rd_bone];
        end
    end

    assign o_rd_row = r_row;

endmodule

/* design/lbs_blend.sv */
// weighted blend of four bone matrices: product stage then round and saturate
// depends on lbs_pkg
module lbs_blend (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_adv,
    input  logic                  i_valid,
    input  lbs_pkg::t_vtx_ctl     i_ctl,
    input  logic [3:0][16:0]      i_wt,
    input  logic [3:0][15:0][31:0] i_rows,
    output logic                  o_valid,
    output lbs_pkg::t_vtx_ctl     o_ctl,
    output logic [15:0][31:0]     o_blend,
    output logic                  o_clip
);

    logic signed [49:0] r_prod [lbs_pkg::NUM_INF][lbs_pkg::NUM_ELEM];
    logic               r_a_valid;
    lbs_pkg::t_vtx_ctl  r_a_ctl;
    logic               r_b_valid;
    lbs_pkg::t_vtx_ctl  r_b_ctl;
    logic [15:0][31:0]  r_blend;
    logic               r_clip;
    logic [15:0][31:0]  n_blend;
    logic               n_clip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else if (i_adv) begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
        end
    end

    // zero weight selects zero so an unread row never leaks in
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int k = 0; k < lbs_pkg::NUM_INF; k++) begin
                for (int e = 0; e < lbs_pkg::NUM_ELEM; e++) begin
                    if (i_wt[k] != '0) begin
                        r_prod[k][e] <= $signed({1'b0, i_wt[k]}) * $signed(i_rows[k][e]);
                    end else begin
                        r_prod[k][e] <= '0;
                    end
                end
            end
            r_a_ctl <= i_ctl;
            r_b_ctl <= r_a_ctl;
            r_blend <= n_blend;
            r_clip  <= n_clip;
        end
    end

    always_comb begin
        logic signed [51:0] sum;
        logic signed [35:0] shr;
        lbs_pkg::t_sat      s;
        n_clip = 1'b0;
        for (int e = 0; e < lbs_pkg::NUM_ELEM; e++) begin
            sum = 52'(r_prod[0][e]) + 52'(r_prod[1][e]) + 52'(r_prod[2][e])
                + 52'(r_prod[3][e]) + 52'sd32768;
            shr = 36'(sum >>> 16);
            s   = lbs_pkg::sat32(66'(shr));
            n_blend[e] = s.val;
            n_clip     = n_clip | s.clip;
        end
    end

    assign o_valid = r_b_valid;
    assign o_ctl   = r_b_ctl;
    assign o_blend = r_blend;
    assign o_clip  = r_clip;

endmodule

/* design/lbs_xform.sv */
// blended matrix times vector, round, saturate, output register
// depends on lbs_pkg
module lbs_xform (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_adv,
    input  logic                  i_valid,
    input  lbs_pkg::t_vtx_ctl     i_ctl,
    input  logic [15:0][31:0]     i_blend,
    input  logic                  i_clip,
    output logic                  o_valid,
    output lbs_pkg::t_out_item    o_item
);

    logic signed [63:0] r_mp [lbs_pkg::NUM_ROW][4];
    logic               r_c_valid;
    lbs_pkg::t_vtx_ctl  r_c_ctl;
    logic               r_c_clip;
    logic               r_out_valid;
    lbs_pkg::t_out_item r_out;
    lbs_pkg::t_out_item n_out;
    logic signed [31:0] vec [3];

    assign vec[0] = i_ctl.x;
    assign vec[1] = i_ctl.y;
    assign vec[2] = i_ctl.z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (i_adv) begin
            r_c_valid   <= i_valid;
            r_out_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int r = 0; r < lbs_pkg::NUM_ROW; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_mp[r][c] <= $signed(i_blend[r*4+c]) * vec[c];
                end
                // w column: times one for a point, nothing for a normal
                if (i_ctl.point) begin
                    r_mp[r][3] <= {{16{i_blend[r*4+3][31]}}, i_blend[r*4+3], 16'h0000};
                end else begin
                    r_mp[r][3] <= '0;
                end
            end
            r_c_ctl  <= i_ctl;
            r_c_clip <= i_clip;
            r_out    <= n_out;
        end
    end

    always_comb begin
        logic signed [65:0] sum;
        logic signed [49:0] shr;
        lbs_pkg::t_sat      s [3];
        logic               clip;
        clip = r_c_clip;
        for (int r = 0; r < lbs_pkg::NUM_ROW; r++) begin
            sum  = 66'(r_mp[r][0]) + 66'(r_mp[r][1]) + 66'(r_mp[r][2])
                 + 66'(r_mp[r][3]) + 66'sd32768;
            shr  = 50'(sum >>> 16);
            s[r] = lbs_pkg::sat32(66'(shr));
            clip = clip | s[r].clip;
        end
        if (r_c_ctl.pass) begin
            n_out.out_x     = r_c_ctl.x;
            n_out.out_y     = r_c_ctl.y;
            n_out.out_z     = r_c_ctl.z;
            n_out.saturated = 1'b0;
        end else begin
            n_out.out_x     = s[0].val;
            n_out.out_y     = s[1].val;
            n_out.out_z     = s[2].val;
            n_out.saturated = clip;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

endmodule

/* design/linear_blend_skinning_core.sv */
// top level of the linear blend skinning core
// depends on lbs_pkg, lbs_bank, lbs_blend, lbs_xform
//
// usage
//  - input channel i_in_valid / o_in_stall carries a t_in_item per transaction
//  - opcode write stores coord_x into the bone table at matrix_slot, no result
//  - opcode point or normal returns one t_out_item on o_out_valid / i_out_stall
//  - opcode three and out-of-range write slots are dropped silently
//  - a vertex result is registered in turn by the table read, products, blend,
//    matrix products and output stages after its transaction is accepted
//  - one transaction per clock unless stalled; writes and vertices mix freely
//  - each influence reads its own copy of the table, so four full matrix rows
//    come out of four memories in the same cycle; a write updates all copies
//  - the pipe moves as one: a stalled full output register freezes every
//    stage and raises o_in_stall in the same cycle
//  - reset clears the pipeline valids only; table contents are undefined
//    until written, and a vertex must only name written matrices
//  - all-zero effective weights pass the vector through unchanged
module linear_blend_skinning_core #(
    parameter int MAX_BONES  = 64,
    parameter int INFLUENCES = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  lbs_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output lbs_pkg::t_out_item  o_out_data
);

    localparam int BONE_W = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;

    logic                    adv;
    logic                    accept;
    logic                    is_vtx;
    logic                    wr_en;
    logic [8:0]              wr_bone_ext;
    logic [3:0][16:0]        n_wt;
    logic [3:0][BONE_W-1:0]  rd_bone;
    logic [3:0][15:0][31:0]  rows;
    logic [16:0]             w_in [4];
    lbs_pkg::t_vtx_ctl       n_ctl;

    logic                    r1_valid;
    logic [3:0][16:0]        r1_wt;
    lbs_pkg::t_vtx_ctl       r1_ctl;

    logic                    b_valid;
    lbs_pkg::t_vtx_ctl       b_ctl;
    logic [15:0][31:0]       b_blend;
    logic                    b_clip;

    // whole pipe advances unless the output register is full and held
    assign adv        = !(o_out_valid && i_out_stall);
    assign o_in_stall = !adv;
    assign accept     = i_in_valid && adv;
    assign is_vtx     = (i_in_data.opcode == lbs_pkg::OP_POINT)
                     || (i_in_data.opcode == lbs_pkg::OP_NORMAL);

    // table write, slots past the table are dropped
    assign wr_en = accept && (i_in_data.opcode == lbs_pkg::OP_WRITE)
                && (int'(i_in_data.matrix_slot) < MAX_BONES * lbs_pkg::NUM_ELEM);
    assign wr_bone_ext = {3'b000, i_in_data.matrix_slot[9:4]};

    assign w_in[0] = i_in_data.weight0;
    assign w_in[1] = i_in_data.weight1;
    assign w_in[2] = i_in_data.weight2;
    assign w_in[3] = i_in_data.weight3;

    // weight clamp to one, unused influences and unknown bones weigh nothing
    always_comb begin
        logic [5:0] id;
        logic [8:0] id_ext;
        logic [16:0] w;
        logic        any;
        any = 1'b0;
        for (int k = 0; k < lbs_pkg::NUM_INF; k++) begin
            id     = i_in_data.bone_ids[k*lbs_pkg::ID_W +: lbs_pkg::ID_W];
            id_ext = {3'b000, id};
            w      = (w_in[k] > lbs_pkg::Q_ONE) ? lbs_pkg::Q_ONE : w_in[k];
            if (k >= INFLUENCES || int'(id) >= MAX_BONES) begin
                w = '0;
            end
            n_wt[k]    = w;
            rd_bone[k] = id_ext[BONE_W-1:0];
            any        = any | (w != '0);
        end
        n_ctl.pass  = !any;
        n_ctl.point = (i_in_data.opcode == lbs_pkg::OP_POINT);
        n_ctl.x     = i_in_data.coord_x;
        n_ctl.y     = i_in_data.coord_y;
        n_ctl.z     = i_in_data.coord_z;
    end

    // one table copy per influence
    for (genvar g = 0; g < lbs_pkg::NUM_INF; g++) begin : g_bank
        if (g < INFLUENCES) begin : g_used
            lbs_bank #(
                .MAX_BONES (MAX_BONES),
                .BONE_W    (BONE_W)
            ) u_bank (
                .i_clk     (i_clk),
                .i_wr_en   (wr_en),
                .i_wr_bone (wr_bone_ext[BONE_W-1:0]),
                .i_wr_elem (i_in_data.matrix_slot[3:0]),
                .i_wr_data (i_in_data.coord_x),
                .i_rd_en   (adv),
                .i_rd_bone (rd_bone[g]),
                .o_rd_row  (rows[g])
            );
        end else begin : g_unused
            assign rows[g] = '0;
        end
    end

    // stage 1 sits alongside the table read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (adv) begin
            r1_valid <= accept && is_vtx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_wt  <= n_wt;
            r1_ctl <= n_ctl;
        end
    end

    lbs_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (r1_valid),
        .i_ctl   (r1_ctl),
        .i_wt    (r1_wt),
        .i_rows  (rows),
        .o_valid (b_valid),
        .o_ctl   (b_ctl),
        .o_blend (b_blend),
        .o_clip  (b_clip)
    );

    lbs_xform u_xform (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (b_valid),
        .i_ctl   (b_ctl),
        .i_blend (b_blend),
        .i_clip  (b_clip),
        .o_valid (o_out_valid),
        .o_item  (o_out_data)
    );

    // a held result is never dropped
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("held result lost");

    // the first stage freezes while the input is stalled
    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |=> $stable(r1_valid))
        else $error("pipe moved under stall");

    // a table write never produces a result
    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_in_data.opcode == lbs_pkg::OP_WRITE) |=> !r1_valid)
        else $error("write transaction entered vertex pipe");

endmodule

/* sim/linear_blend_skinning_core_test.sv */
`timescale 1ns / 100ps
// testbench for the linear blend skinning core: bone table loads and vertex skinning
// depends on lbs_pkg and linear_blend_skinning_core
module linear_blend_skinning_core_test;

    localparam int N_BONES   = 64;
    localparam int CYC_LIMIT = 400000;

    logic               i_clk;
    logic               i_rst_n;
    logic               in_valid;
    logic               in_stall;
    lbs_pkg::t_in_item  in_data;
    logic               out_valid;
    logic               out_stall;
    lbs_pkg::t_out_item out_data;

    linear_blend_skinning_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    // clock, 10 ns period
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // predictor state: our own copy of the bone table and which entries are loaded
    logic [31:0] bone_table [N_BONES*16];
    bit          bone_loaded [N_BONES];
    int          bone_count [N_BONES];

    lbs_pkg::t_in_item  pending_items [$];
    lbs_pkg::t_out_item skinned_results [$];

    int sender_idle_pct;
    int receiver_stall_pct;
    bit hold_sender;
    int error_count;
    int cycle_count;
    int vertex_count;
    int write_count;
    int clip_count;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h (cycle %0d)", what, got, want,
                 cycle_count);
        error_count++;
    endtask

    function automatic void enqueue_item(input lbs_pkg::t_in_item it);
        pending_items.insert(pending_items.size(), it);
    endfunction

    function automatic void enqueue_result(input lbs_pkg::t_out_item r);
        skinned_results.insert(skinned_results.size(), r);
    endfunction

    function automatic longint round_q16(input longint acc);
        return (acc + 64'sd32768) >>> 16;
    endfunction

    function automatic longint clip32(input longint v, inout bit clipped);
        if (v > 64'sd2147483647) begin
            clipped = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            clipped = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // work out the skinned vector, or update the table for a write
    function automatic void predict_skin(input lbs_pkg::t_in_item it);
        longint    vec [4];
        longint    blend [16];
        longint    wt [4];
        int        bone [4];
        bit        any_w;
        bit        clipped;
        longint    acc;
        logic [127:0] racc;
        lbs_pkg::t_out_item r;
        logic [16:0] w_raw;
        any_w   = 1'b0;
        clipped = 1'b0;
        if (it.opcode == lbs_pkg::OP_WRITE) begin
            if (it.matrix_slot < N_BONES*16)
                bone_table[it.matrix_slot] = it.coord_x;
            return;
        end
        if (it.opcode != lbs_pkg::OP_POINT && it.opcode != lbs_pkg::OP_NORMAL)
            return;
        vec[0] = it.coord_x;
        vec[1] = it.coord_y;
        vec[2] = it.coord_z;
        vec[3] = (it.opcode == lbs_pkg::OP_POINT) ? 64'sd65536 : 64'sd0;
        for (int k = 0; k < lbs_pkg::NUM_INF; k++) begin
            case (k)
                0: w_raw = it.weight0;
                1: w_raw = it.weight1;
                2: w_raw = it.weight2;
                default: w_raw = it.weight3;
            endcase
            bone[k] = it.bone_ids[6*k +: 6];
            wt[k] = (w_raw > lbs_pkg::Q_ONE) ? 64'sd65536 : longint'(w_raw);
            if (bone[k] >= N_BONES)
                wt[k] = 0;
            if (wt[k] != 0)
                any_w = 1'b1;
        end
        if (!any_w) begin
            r.out_x = it.coord_x;
            r.out_y = it.coord_y;
            r.out_z = it.coord_z;
            r.saturated = 1'b0;
            enqueue_result(r);
            return;
        end
        for (int e = 0; e < 16; e++) begin
            acc = 0;
            for (int k = 0; k < lbs_pkg::NUM_INF; k++)
                if (wt[k] != 0)
                    acc += wt[k] * longint'($signed(bone_table[bone[k]*16 + e]));
            blend[e] = clip32(round_q16(acc), clipped);
        end
        // products reach 2^62 and their sum can overflow 64 bits, so sum them in 128 bits
        for (int row = 0; row < lbs_pkg::NUM_ROW; row++) begin
            racc = 0;
            for (int c = 0; c < 4; c++)
                racc = $signed(racc) + $signed(128'(blend[row*4 + c]) * 128'(vec[c]));
            racc = ($signed(racc) + 128'sd32768) >>> 16;
            if ($signed(racc) > 128'sd2147483647) begin
                racc = 128'sd2147483647;
                clipped = 1'b1;
            end else if ($signed(racc) < -128'sd2147483648) begin
                racc = -128'sd2147483648;
                clipped = 1'b1;
            end
            case (row)
                0: r.out_x = racc[31:0];
                1: r.out_y = racc[31:0];
                default: r.out_z = racc[31:0];
            endcase
        end
        r.saturated = clipped;
        if (clipped)
            clip_count++;
        enqueue_result(r);
    endfunction

    // driver: feeds the queue one transaction at a time
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall)
                predict_skin(in_data);
            if (!in_valid || !in_stall) begin
                if (pending_items.size() > 0 && !hold_sender
                        && $urandom_range(99) >= sender_idle_pct) begin
                    in_data  <= pending_items.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks results against the oldest expectation, drives the stall
    always @(posedge i_clk) begin
        lbs_pkg::t_out_item want;
        cycle_count++;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                vertex_count++;
                if (skinned_results.size() == 0) begin
                    report_mismatch("unexpected result", out_data.out_x, 32'h0);
                end else begin
                    want = skinned_results.pop_front();
                    if (out_data.out_x !== want.out_x)
                        report_mismatch("out_x", out_data.out_x, want.out_x);
                    if (out_data.out_y !== want.out_y)
                        report_mismatch("out_y", out_data.out_y, want.out_y);
                    if (out_data.out_z !== want.out_z)
                        report_mismatch("out_z", out_data.out_z, want.out_z);
                    if (out_data.saturated !== want.saturated)
                        report_mismatch("saturated", 32'(out_data.saturated),
                                        32'(want.saturated));
                end
            end
            out_stall <= ($urandom_range(99) < receiver_stall_pct);
        end
        if (cycle_count > CYC_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("linear_blend_skinning_core test failed");
            $finish;
        end
    end

    function automatic lbs_pkg::t_in_item blank_item();
        lbs_pkg::t_in_item it;
        it = '0;
        return it;
    endfunction

    // one matrix entry write
    function automatic void queue_entry(input int slot, input logic [31:0] val);
        lbs_pkg::t_in_item it;
        it = blank_item();
        it.opcode = lbs_pkg::OP_WRITE;
        it.matrix_slot = 10'(slot);
        it.coord_x = val;
        it.coord_y = $urandom();
        it.weight0 = 17'($urandom());
        enqueue_item(it);
        write_count++;
    endfunction

    // load a whole bone; kind 0 identity, 1 random moderate, 2 full-range random
    function automatic void queue_bone(input int b, input int kind);
        logic [31:0] v;
        for (int e = 0; e < 16; e++) begin
            case (kind)
                0: v = (e % 5 == 0) ? 32'h0001_0000 : 32'h0;
                1: v = $signed(32'($urandom_range(262143))) - 32'sd131072;
                default: v = $urandom();
            endcase
            queue_entry(b*16 + e, v);
        end
        bone_loaded[b] = 1'b1;
    endfunction

    function automatic logic [16:0] rand_weight();
        case ($urandom_range(5))
            0: return 17'd0;
            1: return lbs_pkg::Q_ONE;
            2: return 17'($urandom());
            default: return 17'($urandom_range(65536));
        endcase
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(3))
            0: return $urandom();
            default: return $signed(32'($urandom_range(1 << 22))) - 32'sd2097152;
        endcase
    endfunction

    // vertex naming only loaded bones
    function automatic void queue_vertex();
        lbs_pkg::t_in_item it;
        int id;
        it = blank_item();
        it.opcode = $urandom_range(1) ? lbs_pkg::OP_POINT : lbs_pkg::OP_NORMAL;
        it.matrix_slot = 10'($urandom());
        for (int k = 0; k < lbs_pkg::NUM_INF; k++) begin
            do id = $urandom_range(N_BONES - 1); while (!bone_loaded[id]);
            it.bone_ids[6*k +: 6] = 6'(id);
        end
        it.weight0 = rand_weight();
        it.weight1 = rand_weight();
        it.weight2 = rand_weight();
        it.weight3 = rand_weight();
        it.coord_x = rand_coord();
        it.coord_y = rand_coord();
        it.coord_z = rand_coord();
        enqueue_item(it);
    endfunction

    task automatic drain(input int gap);
        while (pending_items.size() > 0 || skinned_results.size() > 0 || in_valid)
            @(posedge i_clk);
        repeat (gap) @(posedge i_clk);
    endtask

    initial begin
        lbs_pkg::t_in_item it;
        hold_sender = 1'b0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        i_rst_n = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: identity, extreme and full-scale bones, then edge vertices
        queue_bone(0, 0);
        queue_bone(1, 2);
        for (int e = 0; e < 16; e++)
            queue_entry(2*16 + e, (e % 2) ? 32'h7fff_ffff : 32'h8000_0000);
        bone_loaded[2] = 1'b1;
        it = blank_item();
        it.opcode = lbs_pkg::OP_WRITE;
        it.matrix_slot = 10'h3ff;
        it.coord_x = 32'hdead_beef;
        enqueue_item(it);                      // write slot in range, bone 63
        bone_loaded[63] = 1'b0;
        it = blank_item();
        it.opcode = lbs_pkg::OP_SPARE;         // dropped opcode
        it.coord_x = 32'h1234_5678;
        enqueue_item(it);
        for (int d = 0; d < 8; d++) begin
            it = blank_item();
            it.opcode = (d % 2) ? lbs_pkg::OP_NORMAL : lbs_pkg::OP_POINT;
            it.coord_x = (d < 2) ? 32'h7fff_ffff : rand_coord();
            it.coord_y = (d < 2) ? 32'h8000_0000 : rand_coord();
            it.coord_z = (d == 0) ? 32'hffff_ffff : rand_coord();
            case (d)
                0, 1: ; // all weights zero, pass-through
                2, 3: begin it.weight0 = lbs_pkg::Q_ONE; end
                4: begin it.bone_ids = {6'd2, 6'd2, 6'd2, 6'd2};
                         it.weight0 = lbs_pkg::Q_ONE; it.weight1 = lbs_pkg::Q_ONE;
                         it.weight2 = lbs_pkg::Q_ONE; it.weight3 = lbs_pkg::Q_ONE; end
                5: begin it.bone_ids = {6'd1, 6'd2, 6'd0, 6'd1};
                         it.weight0 = 17'h1ffff; it.weight1 = 17'd1;
                         it.weight2 = 17'h0ffff; it.weight3 = 17'd32768; end
                default: begin it.bone_ids = {6'd0, 6'd1, 6'd2, 6'd0};
                         it.weight0 = rand_weight(); it.weight3 = rand_weight(); end
            endcase
            enqueue_item(it);
        end
        drain(10);

        // random phases: no idling, sender idle, receiver stalls, both
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 70; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 70; end
                3: begin sender_idle_pct = 19; receiver_stall_pct = 19; end
                default: begin sender_idle_pct = 0; receiver_stall_pct = 0; end
            endcase
            for (int b = 0; b < 3; b++)
                queue_bone($urandom_range(N_BONES - 1), $urandom_range(2));
            for (int n = 0; n < 250; n++) begin
                case ($urandom_range(19))
                    0: queue_entry($urandom_range(N_BONES*16 - 1), rand_coord());
                    1: begin
                        it = blank_item();
                        it.opcode = lbs_pkg::OP_SPARE;
                        it.bone_ids = 24'($urandom());
                        enqueue_item(it);
                    end
                    default: queue_vertex();
                endcase
            end
            if (ph == 2) begin
                // pause the sender until every result is back
                wait (pending_items.size() < 100);
                hold_sender = 1'b1;
                while (skinned_results.size() > 0 || in_valid)
                    @(posedge i_clk);
                hold_sender = 1'b0;
            end
            drain(10);
        end

        $display("covered %0d table writes, %0d skinned vertices (%0d with clipping)",
                 write_count, vertex_count, clip_count);
        $display("idling phases none, sender, receiver and both; opcode three dropped");
        if (error_count == 0) begin
            $display("linear_blend_skinning_core test passed");
        end else begin
            $display("linear_blend_skinning_core test failed");
        end
        $finish;
    end

endmodule
